// ----- rtl/lerf_pkg.sv -----
// Shared types, character codes and echo-sequence helpers for the line-edit receive FIFO.
// Used by the controller, the datapath and the top level; depends on nothing.
package lerf_pkg;

	// default ring depth (one slot stays free, so it holds depth-1 bytes)
	localparam int FIFO_DEPTH_DEF = 128;

	// character codes
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_FS     = 8'h1C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DIGIT0 = 8'h30;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	// input operation codes
	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_REMOVE  = 1'b1;

	// result kind codes
	typedef enum logic [1:0] {
		KIND_ECHO    = 2'd0,
		KIND_REMOVED = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	// result sequence emitted for one input word
	typedef enum logic [2:0] {
		SEQ_STATUS,
		SEQ_CHAR,
		SEQ_CRLF,
		SEQ_CARET,
		SEQ_ERASE_CTL,
		SEQ_ERASE_ONE,
		SEQ_REMOVED,
		SEQ_BANG
	} seq_t;

	// which pointer addresses the store read
	typedef enum logic {
		RD_HEAD,
		RD_TAIL_PREV
	} rd_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       push;
		logic       pop;
		logic       unpush;
		logic       fix_nl;
		logic [7:0] wr_byte;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic       empty;
		logic       full;
		logic       has_nl;
		logic [7:0] rd_data;
	} dp_stat_t;

	// index of the final word of a sequence
	function automatic logic [2:0] seq_last(input seq_t seq);
		logic [2:0] r;
		case (seq)
			SEQ_CRLF, SEQ_CARET: r = 3'd1;
			SEQ_ERASE_CTL:       r = 3'd5;
			SEQ_ERASE_ONE:       r = 3'd2;
			default:             r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic kind_t seq_kind(input seq_t seq);
		kind_t r;
		case (seq)
			SEQ_REMOVED, SEQ_BANG: r = KIND_REMOVED;
			SEQ_STATUS:            r = KIND_STATUS;
			default:               r = KIND_ECHO;
		endcase
		return r;
	endfunction

	// byte at position idx of a sequence; ch is the received or removed byte
	function automatic logic [7:0] seq_byte(input seq_t seq, input logic [2:0] idx,
		input logic [7:0] ch);
		logic [7:0] r;
		logic [7:0] caret_b;
		if (ch == 8'h00) begin
			caret_b = CH_DIGIT0;
		end else if (ch == CH_FS) begin
			caret_b = CH_BSLASH;
		end else begin
			caret_b = CH_AT + ch;
		end
		case (seq)
			SEQ_CHAR, SEQ_REMOVED: r = ch;
			SEQ_BANG:              r = CH_BANG;
			SEQ_CRLF:              r = (idx == 3'd0) ? CH_CR : CH_LF;
			SEQ_CARET:             r = (idx == 3'd0) ? CH_CARET : caret_b;
			SEQ_ERASE_CTL:         r = (idx == 3'd2 || idx == 3'd3) ? CH_SPACE : CH_BS;
			SEQ_ERASE_ONE:         r = (idx == 3'd1) ? CH_SPACE : CH_BS;
			default:               r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/line_edit_rx_fifo_core.sv -----
// Line-edit receive FIFO: each word is accepted and decided, the store is read once for a
// remove or erase, then one result word per cycle is stepped out, up to six; start is taken
// again the cycle after the last result. The first result follows S_DECIDE, or S_POP/S_UNPUSH.
// Result words are strobed for one cycle each; the receiver cannot stall.
// Reset clears the pointers (FIFO empty), sets echo on, and idles the controller.
// The character store is not cleared; only occupied entries are ever read.
module line_edit_rx_fifo_core #(
	parameter int FIFO_DEPTH = lerf_pkg::FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       op,
	input  logic [7:0] rx_byte,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	output logic       result_strobe,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last,
	output logic       is_empty,
	output logic       is_full,
	output logic       has_newline
);
	import lerf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lerf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.op            (op),
		.rx_byte       (rx_byte),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.stat          (stat),
		.cmd           (cmd),
		.busy          (busy),
		.result_strobe (result_strobe),
		.out_byte      (out_byte),
		.kind          (kind),
		.last          (last)
	);

	lerf_dpath #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	// status reflects the FIFO after the whole word is applied
	assign is_empty    = stat.empty;
	assign is_full     = stat.full;
	assign has_newline = stat.has_nl;

endmodule

// ----- rtl/lerf_dpath.sv -----
// Datapath: character store with registered read, head/tail/newline pointers, status flags.
// Depends on lerf_pkg for the command and status structs.
module lerf_dpath #(
	parameter int FIFO_DEPTH = lerf_pkg::FIFO_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lerf_pkg::dp_cmd_t  cmd,
	output lerf_pkg::dp_stat_t stat
);
	import lerf_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

	logic [7:0]    mem [FIFO_DEPTH];
	logic [7:0]    rd_q;
	logic [PW-1:0] head_q, tail_q, nl_q;
	logic [PW-1:0] head_nx, tail_nx, tail_pv, rd_addr;
	logic          empty, full;

	// ring neighbors
	assign head_nx = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign tail_pv = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;
	assign rd_addr = (cmd.rd_sel == RD_HEAD) ? head_q : tail_pv;

	assign empty = (head_q == tail_q);
	assign full  = (tail_nx == head_q);

	assign stat.empty   = empty;
	assign stat.full    = full;
	assign stat.has_nl  = !empty && (nl_q != tail_q);
	assign stat.rd_data = rd_q;

	// store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.push && !full) begin
			mem[tail_q] <= cmd.wr_byte;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// advance or step back the pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			nl_q   <= '0;
		end else if (cmd.push) begin
			if (!full) begin
				if (cmd.wr_byte == CH_LF) begin
					nl_q <= tail_q;
				end else if (nl_q == tail_q) begin
					nl_q <= tail_nx;
				end
				tail_q <= tail_nx;
			end
		end else if (cmd.pop) begin
			if (nl_q == head_q) begin
				nl_q <= tail_q;
			end
			head_q <= head_nx;
		end else if (cmd.unpush) begin
			if (nl_q == tail_q) begin
				nl_q <= tail_pv;
			end
			tail_q <= tail_pv;
		end else if (cmd.fix_nl) begin
			// erasing over a newline keeps it; the newline mark lands on it
			nl_q <= tail_pv;
		end
	end

endmodule

// ----- rtl/lerf_ctrl.sv -----
// Controller: accepts a word, decides the FIFO action, then steps out the result sequence.
// Depends on lerf_pkg for command/status structs, sequence codes and helper functions.
module lerf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               op,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  lerf_pkg::dp_stat_t stat,
	output lerf_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               result_strobe,
	output logic [7:0]         out_byte,
	output logic [1:0]         kind,
	output logic               last
);
	import lerf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_POP,
		S_UNPUSH,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic       op_q;
	logic [7:0] byte_q;
	logic       echo_q;
	seq_t       seq_q;
	logic [2:0] idx_q;
	logic       is_erase;
	logic       rd_is_lf;

	assign is_erase = (byte_q == CH_BS) || (byte_q == CH_DEL);
	assign rd_is_lf = (stat.rd_data == CH_LF);

	// state and result-sequence registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_RECEIVE;
			byte_q  <= '0;
			echo_q  <= 1'b1;
			seq_q   <= SEQ_STATUS;
			idx_q   <= '0;
		end else begin
			if (cfg_we) begin
				echo_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= op;
						byte_q  <= (rx_byte == CH_CR) ? CH_LF : rx_byte;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					idx_q <= '0;
					if (op_q == OP_REMOVE) begin
						if (stat.empty) begin
							seq_q   <= SEQ_BANG;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_POP;
						end
					end else if (!echo_q) begin
						seq_q   <= SEQ_STATUS;
						state_q <= S_EMIT;
					end else if (is_erase) begin
						if (stat.empty) begin
							seq_q   <= SEQ_STATUS;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_UNPUSH;
						end
					end else begin
						if (byte_q == CH_LF) begin
							seq_q <= SEQ_CRLF;
						end else if (byte_q < CH_SPACE) begin
							seq_q <= SEQ_CARET;
						end else begin
							seq_q <= SEQ_CHAR;
						end
						state_q <= S_EMIT;
					end
				end
				S_POP: begin
					byte_q  <= stat.rd_data;
					seq_q   <= SEQ_REMOVED;
					state_q <= S_EMIT;
				end
				S_UNPUSH: begin
					if (rd_is_lf) begin
						seq_q <= SEQ_STATUS;
					end else if (stat.rd_data < CH_SPACE) begin
						seq_q <= SEQ_ERASE_CTL;
					end else begin
						seq_q <= SEQ_ERASE_ONE;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (idx_q == seq_last(seq_q)) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// drive datapath commands
	always_comb begin
		cmd         = '0;
		cmd.rd_sel  = RD_HEAD;
		cmd.wr_byte = byte_q;
		case (state_q)
			S_DECIDE: begin
				if (op_q == OP_REMOVE) begin
					cmd.rd_en = !stat.empty;
				end else if (!echo_q) begin
					cmd.push = 1'b1;
				end else if (is_erase) begin
					cmd.rd_en  = !stat.empty;
					cmd.rd_sel = RD_TAIL_PREV;
				end else begin
					cmd.push = 1'b1;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
			end
			S_UNPUSH: begin
				cmd.fix_nl = rd_is_lf;
				cmd.unpush = !rd_is_lf;
			end
			default: begin
				cmd.rd_en = 1'b0;
			end
		endcase
	end

	// result word from the current sequence position
	assign busy          = (state_q != S_IDLE);
	assign result_strobe = (state_q == S_EMIT);
	assign out_byte      = seq_byte(seq_q, idx_q, byte_q);
	assign kind          = seq_kind(seq_q);
	assign last          = (idx_q == seq_last(seq_q));

endmodule

// ----- rtl/lerf_chk.sv -----
// Port-level checker for the line-edit receive FIFO, bound to the top level.
// Depends on lerf_pkg for the result kind codes.
module lerf_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_strobe,
	input logic [1:0] kind,
	input logic       last,
	input logic       is_empty,
	input logic       is_full
);
	import lerf_pkg::*;

	// results only come out while a word is in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result strobe while idle");

	// an accepted word keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("not busy after accept");

	// the final word of a sequence is followed by a gap
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !result_strobe)
		else $error("result word right after last");

	// a status-only word is always the only word
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && kind == KIND_STATUS) |-> last)
		else $error("status word not last");

	// the FIFO is never empty and full at once while a result word is strobed
	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !(is_empty && is_full))
		else $error("empty and full together");

endmodule

bind line_edit_rx_fifo_core lerf_chk u_lerf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.kind          (kind),
	.last          (last),
	.is_empty      (is_empty),
	.is_full       (is_full)
);

// ----- test/tb_top.sv -----
// Self-checking bench for line_edit_rx_fifo_core: receive, erase and remove words are driven
// through start/busy, and every strobed result word is compared with an in-bench line model.
// Depends on lerf_pkg and the core RTL only.
module tb_top;
	import lerf_pkg::*;

	localparam int DEPTH = FIFO_DEPTH_DEF;
	localparam int PW = $clog2(DEPTH);
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 12;

	// one expected result word
	typedef struct packed {
		logic [7:0] chr;
		kind_t      kind_v;
		logic       last_v;
		logic       empty_v;
		logic       full_v;
		logic       nl_v;
	} result_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       op = OP_RECEIVE;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       busy;
	logic       result_strobe;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       last;
	logic       is_empty;
	logic       is_full;
	logic       has_newline;

	// line model state
	logic [7:0]    ring_chars [0:DEPTH-1];
	logic [PW-1:0] head_ix = '0;
	logic [PW-1:0] tail_ix = '0;
	logic [PW-1:0] nl_ix = '0;
	logic          echo_on = 1'b1;

	result_word_t expected_words [$];
	result_word_t got_word;
	int           errors = 0;
	int           words_sent = 0;
	int           words_checked = 0;
	int           burst_left = 0;
	int           cycle_count = 0;

	line_edit_rx_fifo_core #(
		.FIFO_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.rx_byte(rx_byte),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_strobe(result_strobe),
		.out_byte(out_byte),
		.kind(kind),
		.last(last),
		.is_empty(is_empty),
		.is_full(is_full),
		.has_newline(has_newline)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic ring_empty();
		return head_ix == tail_ix;
	endfunction

	function automatic logic ring_full();
		logic [PW-1:0] nt;
		nt = tail_ix + 1'b1;
		return nt == head_ix;
	endfunction

	// append a byte at the tail; drop it when the ring is full
	task automatic ring_push(input logic [7:0] c);
		logic [PW-1:0] nt;
		nt = tail_ix + 1'b1;
		if (nt != head_ix) begin
			if (c == CH_LF) begin
				nl_ix = tail_ix;
			end else if (nl_ix == tail_ix) begin
				nl_ix = nt;
			end
			ring_chars[tail_ix] = c;
			tail_ix = nt;
		end
	endtask

	// advance the line model by one accepted word and queue the result words it yields
	task automatic line_edit_step(input logic op_v, input logic [7:0] ch_in);
		logic [7:0]    c;
		logic [7:0]    t;
		logic [PW-1:0] prev;
		logic [7:0]    seq [$];
		kind_t         k;
		result_word_t  w;
		c = ch_in;
		k = KIND_ECHO;
		if (op_v == OP_REMOVE) begin
			k = KIND_REMOVED;
			if (ring_empty()) begin
				seq.push_back(CH_BANG);
			end else begin
				seq.push_back(ring_chars[head_ix]);
				if (nl_ix == head_ix) begin
					nl_ix = tail_ix;
				end
				head_ix = head_ix + 1'b1;
			end
		end else begin
			if (c == CH_CR) begin
				c = CH_LF;
			end
			if (!echo_on) begin
				ring_push(c);
			end else if (c == CH_BS || c == CH_DEL) begin
				// erase the last byte unless it ends a line
				if (!ring_empty()) begin
					prev = tail_ix - 1'b1;
					if (nl_ix == tail_ix) begin
						nl_ix = prev;
					end
					tail_ix = prev;
					t = ring_chars[tail_ix];
					if (t == CH_LF) begin
						ring_push(CH_LF);
					end else if (t < CH_SPACE) begin
						for (int i = 0; i < 6; i++) begin
							seq.push_back((i == 2 || i == 3) ? CH_SPACE : CH_BS);
						end
					end else begin
						for (int i = 0; i < 3; i++) begin
							seq.push_back((i == 1) ? CH_SPACE : CH_BS);
						end
					end
				end
			end else begin
				// echo, then insert
				if (c == CH_LF) begin
					seq.push_back(CH_CR);
					seq.push_back(CH_LF);
				end else if (c == 8'h00) begin
					seq.push_back(CH_CARET);
					seq.push_back(CH_DIGIT0);
				end else if (c == CH_FS) begin
					seq.push_back(CH_CARET);
					seq.push_back(CH_BSLASH);
				end else if (c < CH_SPACE) begin
					seq.push_back(CH_CARET);
					seq.push_back(CH_AT + c);
				end else begin
					seq.push_back(c);
				end
				ring_push(c);
			end
		end
		if (seq.size() == 0) begin
			seq.push_back(8'h00);
			k = KIND_STATUS;
		end
		foreach (seq[i]) begin
			w.chr = seq[i];
			w.kind_v = k;
			w.last_v = (i == seq.size() - 1);
			w.empty_v = ring_empty();
			w.full_v = ring_full();
			w.nl_v = !ring_empty() && nl_ix != tail_ix;
			expected_words.push_back(w);
		end
	endtask

	// end a burst now and then with an idle gap
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold the word until the core takes it, then predict its results
	task automatic send_word(input logic op_v, input logic [7:0] ch);
		start <= 1'b1;
		op <= op_v;
		rx_byte <= ch;
		do @(posedge clk); while (busy);
		line_edit_step(op_v, ch);
		words_sent++;
		pace();
	endtask

	// drop start and let every outstanding result word arrive
	task automatic wait_all_results();
		start <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_echo(input logic v);
		wait_all_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		echo_on = v;
	endtask

	task automatic drain_ring();
		while (!ring_empty()) begin
			send_word(OP_REMOVE, 8'($urandom));
		end
		send_word(OP_REMOVE, 8'($urandom));
	endtask

	// removes and erases on an empty ring
	task automatic test_empty_ring();
		send_word(OP_REMOVE, 8'h00);
		send_word(OP_RECEIVE, CH_BS);
		send_word(OP_RECEIVE, CH_DEL);
	endtask

	// every echo form and every erase form with echo on
	task automatic test_echo_forms();
		send_word(OP_RECEIVE, 8'h00);
		send_word(OP_RECEIVE, CH_FS);
		send_word(OP_RECEIVE, 8'h01);
		send_word(OP_RECEIVE, 8'h1F);
		send_word(OP_RECEIVE, CH_CR);
		send_word(OP_RECEIVE, CH_SPACE);
		send_word(OP_RECEIVE, 8'h7E);
		send_word(OP_RECEIVE, 8'h80);
		send_word(OP_RECEIVE, 8'hFF);
		send_word(OP_RECEIVE, CH_BS);
		send_word(OP_RECEIVE, CH_DEL);
		send_word(OP_RECEIVE, CH_LF);
		send_word(OP_RECEIVE, CH_BS);
		send_word(OP_RECEIVE, 8'h01);
		send_word(OP_RECEIVE, CH_DEL);
	endtask

	// raw inserts with echo off, then read everything back
	task automatic test_raw_mode();
		set_echo(1'b0);
		send_word(OP_RECEIVE, CH_BS);
		send_word(OP_RECEIVE, CH_DEL);
		send_word(OP_RECEIVE, CH_CR);
		send_word(OP_RECEIVE, 8'hA5);
		drain_ring();
	endtask

	// fill to full, overflow in both modes, erase at full, then empty with wrap
	task automatic test_full_ring();
		while (!ring_full()) begin
			send_word(OP_RECEIVE, 8'($urandom));
		end
		send_word(OP_RECEIVE, 8'($urandom));
		send_word(OP_RECEIVE, CH_CR);
		set_echo(1'b1);
		send_word(OP_RECEIVE, 8'h41);
		send_word(OP_RECEIVE, 8'h03);
		send_word(OP_RECEIVE, CH_CR);
		send_word(OP_RECEIVE, CH_BS);
		send_word(OP_RECEIVE, 8'h5A);
		drain_ring();
	endtask

	// mostly line-like traffic with edits and reads, plus arbitrary bytes
	task automatic test_random_traffic(input int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				send_word(OP_REMOVE, 8'($urandom));
			end else if (r < 42) begin
				send_word(OP_RECEIVE, $urandom_range(0, 1) ? CH_BS : CH_DEL);
			end else if (r < 52) begin
				send_word(OP_RECEIVE, $urandom_range(0, 1) ? CH_CR : CH_LF);
			end else if (r < 80) begin
				send_word(OP_RECEIVE, 8'($urandom_range(32, 126)));
			end else begin
				send_word(OP_RECEIVE, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic cmp_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// compare each strobed word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_strobe === 1'b1) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got byte %0h kind %0d",
					$time, out_byte, kind);
				errors++;
			end else begin
				got_word = expected_words.pop_front();
				cmp_field("out_byte", got_word.chr, out_byte);
				cmp_field("kind", 8'(got_word.kind_v), 8'(kind));
				cmp_field("last", 8'(got_word.last_v), 8'(last));
				cmp_field("is_empty", 8'(got_word.empty_v), 8'(is_empty));
				cmp_field("is_full", 8'(got_word.full_v), 8'(is_full));
				cmp_field("has_newline", 8'(got_word.nl_v), 8'(has_newline));
				words_checked++;
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_ring();
		test_echo_forms();
		test_raw_mode();
		test_full_ring();
		test_random_traffic(20);
		set_echo(1'b0);
		test_random_traffic(10);
		set_echo(1'b1);
		test_random_traffic(20);
		wait_all_results();
		$display("Covered echo forms, erases, raw mode, overflow and random line traffic.");
		$display("%0d words sent, %0d result words checked, %0d mismatches",
			words_sent, words_checked, errors);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- line_edit_rx_fifo_core.f -----
rtl/lerf_pkg.sv
rtl/lerf_dpath.sv
rtl/lerf_ctrl.sv
rtl/line_edit_rx_fifo_core.sv
rtl/lerf_chk.sv
test/tb_top.sv
